### sv/rpr_pkg.sv
`default_nettype none

package rpr_pkg;

    // input action codes
    localparam logic [2:0] ACT_READ_BYTE  = 3'd0;
    localparam logic [2:0] ACT_READ_WORD  = 3'd1;
    localparam logic [2:0] ACT_WRITE_BYTE = 3'd2;
    localparam logic [2:0] ACT_WRITE_WORD = 3'd3;
    localparam logic [2:0] ACT_TICK       = 3'd4;
    localparam logic [2:0] ACT_LOOKUP     = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_RED_MASK   = 2'd0;
    localparam logic [1:0] CFG_GREEN_MASK = 2'd1;
    localparam logic [1:0] CFG_BLUE_MASK  = 2'd2;

    localparam logic [31:0] RED_MASK_RST   = 32'hFF00_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h00FF_0000;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_FF00;

    // bus decode
    localparam logic [23:0] HIGH_LIMIT   = 24'hE8_2400;
    localparam logic [3:0]  CONTRAST_RST = 4'd15;
    localparam logic [3:0]  CONTRAST_MAX = 4'd15;

    // divide by fifteen: q = (p * DIV15_MUL) >> DIV15_SHIFT, exact for p < 74898
    localparam logic [15:0] DIV15_MUL   = 16'd34953;
    localparam int          DIV15_SHIFT = 19;

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;

    // color converter control
    typedef struct packed {
        logic load;     // capture entry and contrast, form products
        logic step;     // divide products by fifteen
    } conv_ctrl_t;

endpackage

`default_nettype wire

### sv/rpr_ram.sv
`default_nettype none

module rpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/rpr_conv.sv
`default_nettype none

module rpr_conv (
    input  wire logic               clk,
    input  wire rpr_pkg::conv_ctrl_t ctrl,
    input  wire logic [15:0]        word,
    input  wire logic [3:0]         contrast,
    input  wire logic [31:0]        red_mask,
    input  wire logic [31:0]        green_mask,
    input  wire logic [31:0]        blue_mask,
    output logic      [31:0]        color
);

    import rpr_pkg::*;

    logic        ibit;
    logic [5:0]  ch [3];            // 0 red, 1 green, 2 blue
    logic [11:0] prod_reg [3];
    logic        ibit1_reg;
    logic [27:0] recip [3];
    logic [7:0]  quot_reg [3];
    logic        ibit2_reg;

    // split GGGGG RRRRR BBBBB I into 6-bit channels
    always_comb
    begin
        ibit  = word[0];
        ch[0] = {word[10:6], ibit};
        ch[1] = {word[15:11], ibit};
        ch[2] = {word[5:1], ibit};
    end

    // stage one: channel times four times contrast
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= {10'(ch[i]) * 10'(contrast), 2'b00};
            end
            ibit1_reg <= ibit;
        end
    end

    // stage two: truncating divide by fifteen via reciprocal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            recip[i] = prod_reg[i] * DIV15_MUL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                quot_reg[i] <= recip[i][DIV15_SHIFT+7:DIV15_SHIFT];
            end
            ibit2_reg <= ibit1_reg;
        end
    end

    // place channels, apply masks, set low bit from intensity
    assign color = ({quot_reg[0], 24'd0} & red_mask)
                 | ({8'd0, quot_reg[1], 16'd0} & green_mask)
                 | ({16'd0, quot_reg[2], 8'd0} & blue_mask)
                 | {31'd0, ibit2_reg};

endmodule

`default_nettype wire

### sv/rgbi_palette_ram_with_contrast.sv
`default_nettype none

// Palette RAM of big-endian 16-bit GGGGG RRRRR BBBBB I entries (graphic half
// then text half) with a contrast level and on-demand conversion to 32-bit
// RGBA. Each input transaction gives exactly one output transaction. Bus
// reads, writes and contrast ticks go from acceptance to the output register
// through accepting and issuing the palette read, the read-modify-write and
// the result load; a lookup adds the second stage of the color scaling
// (multiply, then divide by fifteen through a reciprocal) before the load,
// and the load waits while the output still holds an unaccepted result. One
// item is in work at a time; the input is taken again as soon as the result
// is loaded, even while that result still waits on the output. After reset a
// clearing pass zeroes every palette entry before the first input transaction
// is accepted; configuration writes are taken at any time.
module rgbi_palette_ram_with_contrast #(
    parameter int PALETTE_ENTRIES = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // address[23:0], write_data[39:24], genuine_byte_access[40],
    // contrast_target[44:41], entry_index[53:45], zero pad
    input  wire logic [rpr_pkg::S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  wire logic [rpr_pkg::S_TUSER_W-1:0] s_tuser,
    // master stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_data[15:0], color[47:16], screen_dirty[48], zero pad
    output logic      [rpr_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [31:0]                   cfg_wdata
);

    import rpr_pkg::*;

    localparam int AW        = $clog2(PALETTE_ENTRIES);
    localparam int MOD_STEPS = $clog2(511 / PALETTE_ENTRIES + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CONV  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // entry number modulo the palette size by compare and subtract
    function automatic logic [AW-1:0] wrap_entry(input logic [8:0] v);
        logic [9:0] r;
        logic [9:0] sub;
        r = {1'b0, v};
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            sub = 10'(PALETTE_ENTRIES) << k;
            if (r >= sub)
            begin
                r = r - sub;
            end
        end
        return r[AW-1:0];
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [3:0]    contrast_reg, contrast_next;
    logic [31:0]   red_mask_reg, green_mask_reg, blue_mask_reg;

    // captured item
    logic [2:0]    act_reg;
    logic [23:0]   addr_reg;
    logic [15:0]   wdata_reg;
    logic          genuine_reg;
    logic [3:0]    target_reg;
    logic [AW-1:0] slot_reg;

    // pending result
    logic [15:0]   res_rdata_reg, res_rdata_next;
    logic          res_dirty_reg, res_dirty_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          accept;
    logic [2:0]    in_action;
    logic [23:0]   in_address;
    logic [8:0]    in_entry;
    logic [AW-1:0] rd_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [15:0]   mem_rdata;

    conv_ctrl_t    conv_ctrl;
    logic [31:0]   conv_color;

    logic          low_addr;
    logic          odd;
    logic          text_half;
    logic [7:0]    old_byte;
    logic [7:0]    new_byte;
    logic          out_free;

    // input fields
    assign in_action  = s_tuser;
    assign in_address = s_tdata[23:0];
    assign in_entry   = s_tdata[53:45];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // palette read address from the incoming item
    assign rd_addr = (in_action == ACT_LOOKUP) ? wrap_entry(in_entry)
                                               : wrap_entry(in_address[9:1]);

    rpr_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    rpr_conv u_conv (
        .clk        (clk),
        .ctrl       (conv_ctrl),
        .word       (mem_rdata),
        .contrast   (contrast_reg),
        .red_mask   (red_mask_reg),
        .green_mask (green_mask_reg),
        .blue_mask  (blue_mask_reg),
        .color      (conv_color)
    );

    // address decode of the captured item
    assign low_addr  = addr_reg < HIGH_LIMIT;
    assign odd       = addr_reg[0];
    assign text_half = addr_reg[9];
    assign old_byte  = odd ? mem_rdata[7:0] : mem_rdata[15:8];
    assign new_byte  = wdata_reg[7:0];

    // sequencer, read-modify-write and result assembly
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        contrast_next  = contrast_reg;
        res_rdata_next = res_rdata_reg;
        res_dirty_next = res_dirty_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = wdata_reg;
        conv_ctrl      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 16'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(PALETTE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                res_rdata_next = 16'd0;
                res_dirty_next = 1'b0;
                state_next     = ST_OUT;
                case (act_reg)
                    ACT_READ_BYTE:
                    begin
                        res_rdata_next = low_addr ? {8'd0, old_byte} : 16'h00FF;
                    end
                    ACT_READ_WORD:
                    begin
                        res_rdata_next = low_addr ? mem_rdata : 16'hFFFF;
                    end
                    ACT_WRITE_BYTE:
                    begin
                        mem_wdata = odd ? {mem_rdata[15:8], new_byte}
                                        : {new_byte, mem_rdata[7:0]};
                        if (low_addr && (old_byte != new_byte)
                            && !(text_half && genuine_reg))
                        begin
                            mem_we         = 1'b1;
                            res_dirty_next = 1'b1;
                        end
                    end
                    ACT_WRITE_WORD:
                    begin
                        mem_wdata = wdata_reg;
                        if (low_addr && (mem_rdata != wdata_reg))
                        begin
                            mem_we         = 1'b1;
                            res_dirty_next = 1'b1;
                        end
                    end
                    ACT_TICK:
                    begin
                        if (target_reg > contrast_reg)
                        begin
                            contrast_next  = contrast_reg + 4'd1;
                            res_dirty_next = 1'b1;
                        end
                        else if (target_reg < contrast_reg)
                        begin
                            contrast_next  = contrast_reg - 4'd1;
                            res_dirty_next = 1'b1;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        conv_ctrl.load = 1'b1;
                        state_next     = ST_CONV;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CONV:
            begin
                conv_ctrl.step = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, res_dirty_reg,
                                     (act_reg == ACT_LOOKUP) ? conv_color : 32'd0,
                                     res_rdata_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            contrast_reg   <= CONTRAST_RST;
            m_tvalid_reg   <= 1'b0;
            red_mask_reg   <= RED_MASK_RST;
            green_mask_reg <= GREEN_MASK_RST;
            blue_mask_reg  <= BLUE_MASK_RST;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            contrast_reg <= contrast_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RED_MASK:   red_mask_reg   <= cfg_wdata;
                    CFG_GREEN_MASK: green_mask_reg <= cfg_wdata;
                    CFG_BLUE_MASK:  blue_mask_reg  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= in_action;
            addr_reg    <= in_address;
            wdata_reg   <= s_tdata[39:24];
            genuine_reg <= s_tdata[40];
            target_reg  <= s_tdata[44:41];
            slot_reg    <= wrap_entry(in_address[9:1]);
        end
        res_rdata_reg <= res_rdata_next;
        res_dirty_reg <= res_dirty_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // no item taken before the clearing pass has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during palette clear");

    // palette only written by the clear pass or the update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_READ))
        else $error("palette write outside clear or update");

    // contrast moves one step at most
    assert property (@(posedge clk) disable iff (!rst_n)
        (contrast_reg != $past(contrast_reg)) |->
            (contrast_reg == $past(contrast_reg) + 4'd1 ||
             contrast_reg == $past(contrast_reg) - 4'd1))
        else $error("contrast jumped by more than one step");

    // an accepted item always goes to the palette read next
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ))
        else $error("accepted item did not start a palette read");

endmodule

`default_nettype wire

### verif/palette_check_pkg.sv
package palette_check_pkg;

    import rpr_pkg::*;

    localparam int PAL_DEPTH = 512;

    // one output transaction: read_data, color, screen_dirty
    typedef struct packed {
        logic [15:0] read_data;
        logic [31:0] color;
        logic        dirty;
    } pal_output_t;

    class palette_scoreboard;

        // predicted block state
        logic [15:0] pal_mem [PAL_DEPTH];
        logic [3:0]  contrast;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;

        pal_output_t palette_outputs_q[$];
        int          mismatches;

        function new();
            foreach (pal_mem[i])
                pal_mem[i] = 16'h0000;
            contrast   = CONTRAST_RST;
            red_mask   = RED_MASK_RST;
            green_mask = GREEN_MASK_RST;
            blue_mask  = BLUE_MASK_RST;
            mismatches = 0;
        endfunction

        function void set_mask(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_RED_MASK:   red_mask = val;
                CFG_GREEN_MASK: green_mask = val;
                CFG_BLUE_MASK:  blue_mask = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] entry_value(logic [8:0] slot);
            return pal_mem[slot];
        endfunction

        function int pending();
            return palette_outputs_q.size();
        endfunction

        // 6-bit channel times 4*contrast, truncating divide by fifteen
        function logic [31:0] scale_chan(logic [5:0] ch);
            int unsigned p;
            p = 32'(ch) * 32'(contrast) * 4;
            return 32'(p / 15);
        endfunction

        // GGGGG RRRRR BBBBB I to RGBA
        function logic [31:0] to_rgba(logic [15:0] v);
            logic [5:0]  g;
            logic [5:0]  r;
            logic [5:0]  b;
            logic [31:0] c;
            g = {v[15:11], v[0]};
            r = {v[10:6], v[0]};
            b = {v[5:1], v[0]};
            c = ((scale_chan(r) << 24) & red_mask)
              | ((scale_chan(g) << 16) & green_mask)
              | ((scale_chan(b) << 8) & blue_mask);
            if (v[0])
                c[0] = 1'b1;
            return c;
        endfunction

        // update the predicted state for one accepted input transaction
        function void note_access(logic [2:0] act, logic [S_TDATA_W-1:0] data);
            logic [23:0] addr;
            logic [15:0] wd;
            logic        genuine;
            logic [3:0]  tgt;
            logic [8:0]  ent;
            logic [8:0]  slot;
            logic        odd;
            logic        low_addr;
            logic [15:0] word;
            logic [7:0]  old_byte;
            pal_output_t res;
            addr     = data[23:0];
            wd       = data[39:24];
            genuine  = data[40];
            tgt      = data[44:41];
            ent      = data[53:45];
            slot     = addr[9:1];
            odd      = addr[0];
            low_addr = addr < HIGH_LIMIT;
            word     = pal_mem[slot];
            old_byte = odd ? word[7:0] : word[15:8];
            res      = '0;
            case (act)
                ACT_READ_BYTE:
                    res.read_data = low_addr ? {8'h00, old_byte} : 16'h00FF;
                ACT_READ_WORD:
                    res.read_data = low_addr ? word : 16'hFFFF;
                ACT_WRITE_BYTE:
                    // genuine byte writes to the text half are dropped
                    if (low_addr && old_byte != wd[7:0] && !(addr[9] && genuine)) begin
                        if (odd)
                            pal_mem[slot] = {word[15:8], wd[7:0]};
                        else
                            pal_mem[slot] = {wd[7:0], word[7:0]};
                        res.dirty = 1'b1;
                    end
                ACT_WRITE_WORD:
                    if (low_addr && word != wd) begin
                        pal_mem[slot] = wd;
                        res.dirty = 1'b1;
                    end
                ACT_TICK:
                    if (tgt != contrast) begin
                        if (tgt > contrast)
                            contrast = contrast + 4'd1;
                        else
                            contrast = contrast - 4'd1;
                        res.dirty = 1'b1;
                    end
                ACT_LOOKUP:
                    res.color = to_rgba(pal_mem[ent]);
                default: ;
            endcase
            palette_outputs_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                if (mismatches < 10)
                    $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        // compare one output transaction against the oldest prediction
        function void check_output(logic [M_TDATA_W-1:0] data);
            pal_output_t exp_r;
            if (palette_outputs_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected output transaction: %h", data);
                mismatches++;
            end
            else begin
                exp_r = palette_outputs_q.pop_front();
                compare_field("read_data", 32'(exp_r.read_data), 32'(data[15:0]));
                compare_field("color", exp_r.color, data[47:16]);
                compare_field("screen_dirty", 32'(exp_r.dirty), 32'(data[48]));
            end
        endfunction

    endclass

endpackage

### verif/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rpr_pkg::*;
    import palette_check_pkg::*;

    // unused action codes
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 300;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_addr  = '0;
    logic [31:0]          cfg_wdata = '0;

    palette_scoreboard sb = new();

    logic       quiet     = 1'b0;
    logic [3:0] tick_goal = CONTRAST_MAX;
    int         hold_cycles = 0;
    int         idle_cycles = 0;

    rgbi_palette_ram_with_contrast DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: check every transaction, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata);
        if (hold_cycles > 0)
            hold_cycles = hold_cycles - 1;
        else
            hold_cycles = pick_gap();
        m_tready <= (hold_cycles == 0);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one input transaction; valid stays high until the next gap or drain
    task automatic send_fields(input logic [2:0] act, input logic [23:0] addr,
                               input logic [15:0] wd, input logic genuine,
                               input logic [3:0] tgt, input logic [8:0] ent);
        logic [S_TDATA_W-1:0] data;
        int                   gap;
        data = {2'b00, ent, tgt, genuine, wd, addr};
        gap  = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_access(act, data);
    endtask

    // stop sending and wait until every predicted output has come
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_masks(input logic [31:0] red, input logic [31:0] green,
                               input logic [31:0] blue);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RED_MASK;
        cfg_wdata <= red;
        @(posedge clk);
        cfg_addr  <= CFG_GREEN_MASK;
        cfg_wdata <= green;
        @(posedge clk);
        cfg_addr  <= CFG_BLUE_MASK;
        cfg_wdata <= blue;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_mask(CFG_RED_MASK, red);
        sb.set_mask(CFG_GREEN_MASK, green);
        sb.set_mask(CFG_BLUE_MASK, blue);
    endtask

    // random access, biased to a few entries so writes and lookups meet
    task automatic send_random();
        logic [2:0]  act;
        logic [23:0] addr;
        logic [15:0] wd;
        logic [15:0] word;
        logic [8:0]  slot;
        logic [8:0]  ent;
        logic [3:0]  tgt;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 12)
            act = ACT_READ_BYTE;
        else if (r < 24)
            act = ACT_READ_WORD;
        else if (r < 44)
            act = ACT_WRITE_BYTE;
        else if (r < 62)
            act = ACT_WRITE_WORD;
        else if (r < 76)
            act = ACT_TICK;
        else if (r < 96)
            act = ACT_LOOKUP;
        else
            act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;

        if ($urandom_range(0, 1))
            slot = 9'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 9'h100 : 9'h000);
        else
            slot = 9'($urandom);

        r = $urandom_range(0, 99);
        if (r < 8)
            addr = 24'($urandom);
        else if (r < 16)
            addr = 24'($urandom_range(HIGH_LIMIT, 24'hFF_FFFF));
        else if (r < 18)
            addr = $urandom_range(0, 1) ? HIGH_LIMIT : HIGH_LIMIT - 24'd1;
        else
            addr = {14'($urandom_range(0, 14'h3A08)), slot, 1'($urandom)};

        // some writes repeat the stored value
        word = sb.entry_value(addr[9:1]);
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            if (act == ACT_WRITE_BYTE)
                wd = {8'($urandom), addr[0] ? word[7:0] : word[15:8]};
            else
                wd = word;
        end
        else if (r < 40)
            wd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            wd = 16'($urandom);

        if (act == ACT_TICK && $urandom_range(0, 9) < 7)
            tgt = tick_goal;
        else
            tgt = 4'($urandom);

        ent = ($urandom_range(0, 9) < 6) ? slot : 9'($urandom);
        send_fields(act, addr, wd, 1'($urandom), tgt, ent);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: cleared table, word and byte access, unchanged write
        send_fields(ACT_READ_WORD, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_LOOKUP, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_WRITE_WORD, 24'h00_0000, 16'hFFFF, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_WRITE_WORD, 24'h00_0000, 16'hFFFF, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_BYTE, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_BYTE, 24'h00_0001, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_WRITE_BYTE, 24'h00_0001, 16'hFF00, 1'b1, CONTRAST_MAX, 9'd0);
        // word access at an odd address
        send_fields(ACT_READ_WORD, 24'h00_0001, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_LOOKUP, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        // last text entry, intensity bit only
        send_fields(ACT_WRITE_WORD, 24'h00_03FE, 16'h0001, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_LOOKUP, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd511);
        // genuine byte write to text half is dropped, a non-genuine one lands
        send_fields(ACT_WRITE_BYTE, 24'h00_0200, 16'h00AB, 1'b1, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_WORD, 24'h00_0200, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_WRITE_BYTE, 24'h00_0200, 16'h00AB, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_BYTE, 24'h00_0200, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        // high address region
        send_fields(ACT_WRITE_WORD, HIGH_LIMIT, 16'h1234, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_WORD, HIGH_LIMIT, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_BYTE, 24'hFF_FFFF, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_READ_WORD, HIGH_LIMIT - 24'd1, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        // contrast already at target, then one step down
        send_fields(ACT_TICK, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_TICK, 24'h00_0000, 16'h0000, 1'b0, 4'd0, 9'd0);
        send_fields(ACT_WRITE_WORD, 24'h00_0002, 16'hF83F, 1'b0, CONTRAST_MAX, 9'd0);
        send_fields(ACT_LOOKUP, 24'h00_0000, 16'h0000, 1'b0, CONTRAST_MAX, 9'd1);
        send_fields(ACT_SPARE_LO, 24'h00_0000, 16'hFFFF, 1'b1, CONTRAST_MAX, 9'd0);
        send_fields(ACT_SPARE_HI, 24'h00_0002, 16'hFFFF, 1'b1, 4'd0, 9'd1);

        // random phases, masks changed only with the block drained
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_outputs();
                case (phase)
                    1: write_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    2: write_masks(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
                    3: write_masks($urandom, $urandom, $urandom);
                    default: write_masks(RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 100 == 0)
                begin
                    quiet = ($urandom_range(0, 4) == 0);
                    case ($urandom_range(0, 2))
                        0: tick_goal = 4'd0;
                        1: tick_goal = CONTRAST_MAX;
                        default: tick_goal = 4'($urandom);
                    endcase
                end
                send_random();
            end
        end

        quiet = 1'b0;
        drain_outputs();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
